/* rtl/wpi_pkg.sv */
// ---------------------------------------------------------------------------
// wpi_pkg
// Shared types and constants for the waypoint path interpolator.
// ---------------------------------------------------------------------------
package wpi_pkg;

    localparam int MaxWaypointsDef    = 64;
    localparam int MaxSegmentPointsDef = 4095;
    localparam int IterW              = 6;
    localparam logic [IterW-1:0] ITER_LAST = 6'd32;

    localparam logic [1:0] CFG_WCOUNT = 2'd0;
    localparam logic [1:0] CFG_DWELL  = 2'd1;
    localparam logic [1:0] CFG_PPD    = 2'd2;
    localparam logic [1:0] CFG_DELAY  = 2'd3;

    localparam logic KIND_LOAD = 1'b0;

    typedef struct packed {
        logic               kind;
        logic [5:0]         wp_index;
        logic signed [31:0] wp_x;
        logic signed [31:0] wp_y;
        logic [31:0]        elapsed_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               pos_valid;
        logic               advanced;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_DELAY,
        PH_SEG,
        PH_LAST
    } t_phase;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_TICK,
        OP_ENTER_SEG,
        OP_SET_LAST,
        OP_RD_SEG0,
        OP_RD_SEG1,
        OP_DIFF,
        OP_SQ,
        OP_SQRT_INIT,
        OP_SQRT,
        OP_MUL,
        OP_SKIP,
        OP_DIV_INIT,
        OP_DIV,
        OP_DIV_FIN,
        OP_ADVANCE,
        OP_FIRST,
        OP_RD_PT,
        OP_PT_MUL,
        OP_PT_SUM,
        OP_EMIT_POS,
        OP_EMIT_ZERO
    } t_op;

    typedef struct packed {
        t_op  op;
        logic adv;
    } t_cmd;

    typedef struct packed {
        t_phase phase;
        logic   delay_done;
        logic   seg_active;
        logic   seg_end;
        logic   npts_zero;
        logic   iter_last;
        logic   below_dwell;
        logic   first_pending;
        logic   out_free;
    } t_status;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SETTLE,
        ST_RD1,
        ST_DIFF,
        ST_SQ,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_DIV_FIN,
        ST_DECIDE,
        ST_RD_PT,
        ST_PT_MUL,
        ST_PT_SUM,
        ST_EMIT,
        ST_EMIT_ZERO
    } t_state;

endpackage

/* rtl/waypoint_path_interpolator_core.sv */
// ---------------------------------------------------------------------------
// waypoint_path_interpolator_core
// Walks a piecewise linear path over a loaded waypoint table: one point per
// tick that reaches the dwell time or is the first, else a zero item.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// in        input      i_in_valid/o_in_stall    t_in_item
// out       output     o_out_valid/i_out_stall  t_out_item
// cfg       input      i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// A load item writes the table without a stall. A tick settles the walk, then
// gives the first point, advances to the next point or gives a zero item;
// each segment entered runs a 33-step squarer, 33-step square root and
// 33-step divider, each segment skipped runs only the squarer and the root.
// One item is in work at a time; a full output register holds the emit step.
// Reset is synchronous; no clearing pass, the table is undefined until loaded.
// ---------------------------------------------------------------------------
module waypoint_path_interpolator_core
    import wpi_pkg::*;
#(
    parameter int MAX_WAYPOINTS      = MaxWaypointsDef,
    parameter int MAX_SEGMENT_POINTS = MaxSegmentPointsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    wpi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in_data.kind),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    wpi_dp #(
        .MAX_WAYPOINTS      (MAX_WAYPOINTS),
        .MAX_SEGMENT_POINTS (MAX_SEGMENT_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

/* rtl/wpi_ctrl.sv */
// ---------------------------------------------------------------------------
// wpi_ctrl
// Sequencer: settles the walk, runs segment setup, decides and emits.
// ---------------------------------------------------------------------------
module wpi_ctrl
    import wpi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_kind,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_adv, n_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_adv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_adv   <= n_adv;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_adv     = r_adv;
        o_cmd.op  = OP_NONE;
        o_cmd.adv = r_adv;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == KIND_LOAD) begin
                        o_cmd.op = OP_LOAD;
                    end else begin
                        o_cmd.op = OP_TICK;
                        n_adv    = 1'b0;
                        n_state  = ST_SETTLE;
                    end
                end
            end
            ST_SETTLE: begin
                case (i_status.phase)
                    PH_DELAY: begin
                        if (i_status.delay_done) begin
                            o_cmd.op = OP_ENTER_SEG;
                        end else begin
                            n_state = ST_DECIDE;
                        end
                    end
                    PH_SEG: begin
                        if (i_status.seg_active) begin
                            n_state = ST_DECIDE;
                        end else if (i_status.seg_end) begin
                            o_cmd.op = OP_SET_LAST;
                            n_state  = ST_DECIDE;
                        end else begin
                            o_cmd.op = OP_RD_SEG0;
                            n_state  = ST_RD1;
                        end
                    end
                    PH_LAST: n_state = ST_DECIDE;
                    default: o_cmd.op = OP_SET_LAST;
                endcase
            end
            ST_RD1: begin
                o_cmd.op = OP_RD_SEG1;
                n_state  = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = ST_SQ;
            end
            ST_SQ: begin
                o_cmd.op = OP_SQ;
                if (i_status.iter_last) n_state = ST_SQRT_INIT;
            end
            ST_SQRT_INIT: begin
                o_cmd.op = OP_SQRT_INIT;
                n_state  = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (i_status.iter_last) n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = ST_CHK;
            end
            ST_CHK: begin
                if (i_status.npts_zero) begin
                    o_cmd.op = OP_SKIP;
                    n_state  = ST_SETTLE;
                end else begin
                    o_cmd.op = OP_DIV_INIT;
                    n_state  = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_status.iter_last) n_state = ST_DIV_FIN;
            end
            ST_DIV_FIN: begin
                o_cmd.op = OP_DIV_FIN;
                n_state  = ST_SETTLE;
            end
            ST_DECIDE: begin
                if (r_adv) begin
                    n_state = ST_RD_PT;
                end else if (i_status.below_dwell) begin
                    if (i_status.first_pending) begin
                        o_cmd.op = OP_FIRST;
                        n_state  = ST_RD_PT;
                    end else begin
                        n_state = ST_EMIT_ZERO;
                    end
                end else begin
                    o_cmd.op = OP_ADVANCE;
                    n_adv    = 1'b1;
                    n_state  = ST_SETTLE;
                end
            end
            ST_RD_PT: begin
                o_cmd.op = OP_RD_PT;
                n_state  = ST_PT_MUL;
            end
            ST_PT_MUL: begin
                o_cmd.op = OP_PT_MUL;
                n_state  = ST_PT_SUM;
            end
            ST_PT_SUM: begin
                o_cmd.op = OP_PT_SUM;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT_POS;
                    n_state  = ST_IDLE;
                end
            end
            ST_EMIT_ZERO: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT_ZERO;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

/* rtl/wpi_dp.sv */
// ---------------------------------------------------------------------------
// wpi_dp
// Datapath: waypoint memory, walk registers, shift-add squarer, bit-pair
// square root, restoring dividers, point arithmetic and output register.
// ---------------------------------------------------------------------------
module wpi_dp
    import wpi_pkg::*;
#(
    parameter int MAX_WAYPOINTS      = MaxWaypointsDef,
    parameter int MAX_SEGMENT_POINTS = MaxSegmentPointsDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    input  t_in_item  i_in_data,
    input  logic      i_cfg_valid,
    input  logic [1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);
    localparam int EW = (CW > 7) ? CW : 7;
    localparam int IW = (AW > 6) ? AW : 6;
    localparam int PW = $clog2(MAX_SEGMENT_POINTS + 1);

    // configuration
    logic [6:0]  r_wcount;
    logic [31:0] r_dwell;
    logic [15:0] r_ppd;
    logic [7:0]  r_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcount <= 7'd2;
            r_dwell  <= 32'd1000;
            r_ppd    <= 16'd256;
            r_delay  <= 8'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WCOUNT: r_wcount <= i_cfg_data[6:0];
                CFG_DWELL:  r_dwell  <= i_cfg_data;
                CFG_PPD:    r_ppd    <= i_cfg_data[15:0];
                CFG_DELAY:  r_delay  <= i_cfg_data[7:0];
                default:    r_delay  <= r_delay;
            endcase
        end
    end

    logic [EW-1:0] w_wc, w_eff;
    assign w_wc  = EW'(r_wcount);
    assign w_eff = (w_wc == '0) ? EW'(1) :
                   ((w_wc > EW'(MAX_WAYPOINTS)) ? EW'(MAX_WAYPOINTS) : w_wc);

    // walk state
    t_phase        r_phase;
    logic [7:0]    r_delay_pos;
    logic [AW-1:0] r_seg;
    logic [PW-1:0] r_step_idx, r_pts;
    logic [31:0]   r_step_x, r_step_y;
    logic          r_first;
    logic [31:0]   r_elapsed;

    // memory
    logic [63:0]   r_mem [MAX_WAYPOINTS];
    logic [63:0]   r_rdata;
    logic [63:0]   r_base;
    logic [AW-1:0] w_raddr;
    logic          w_rd;
    logic [IW-1:0] w_widx;
    logic [EW-1:0] w_last;

    assign w_widx = IW'(i_in_data.wp_index);
    assign w_last = w_eff - EW'(1);

    always_comb begin
        w_rd    = 1'b1;
        w_raddr = r_seg;
        case (i_cmd.op)
            OP_RD_SEG0: w_raddr = r_seg;
            OP_RD_SEG1: w_raddr = r_seg + AW'(1);
            OP_RD_PT: begin
                case (r_phase)
                    PH_DELAY: w_raddr = '0;
                    PH_SEG:   w_raddr = r_seg;
                    default:  w_raddr = w_last[AW-1:0];
                endcase
            end
            default: w_rd = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD && 32'(w_widx) < 32'(MAX_WAYPOINTS)) begin
            r_mem[w_widx[AW-1:0]] <= {i_in_data.wp_x, i_in_data.wp_y};
        end
        if (w_rd) r_rdata <= r_mem[w_raddr];
    end

    // segment arithmetic
    logic [32:0]   w_dx, w_dy;
    logic [32:0]   r_mag_x, r_mag_y;
    logic          r_neg_x, r_neg_y;
    logic [65:0]   r_mc_x, r_mc_y, r_acc_x, r_acc_y;
    logic [IterW-1:0] r_cnt;
    logic [66:0]   r_op, r_res, r_one, w_trial;
    logic [49:0]   r_nprod;
    logic [25:0]   w_nhi;
    logic [PW-1:0] w_nsat;
    logic [32:0]   r_qx, r_qy;
    logic [PW-1:0] r_rem_x, r_rem_y;
    logic [PW:0]   w_tx, w_ty;
    logic [31:0]   r_prod_x, r_prod_y;
    logic [PW+31:0] w_mx, w_my;
    logic [PW-1:0] w_mf;

    assign w_dx = {r_rdata[63], r_rdata[63:32]} - {r_base[63], r_base[63:32]};
    assign w_dy = {r_rdata[31], r_rdata[31:0]} - {r_base[31], r_base[31:0]};
    assign w_trial = r_res + r_one;
    assign w_nhi = r_nprod[49:24];
    assign w_nsat = (w_nhi > 26'(MAX_SEGMENT_POINTS)) ? PW'(MAX_SEGMENT_POINTS)
                                                       : w_nhi[PW-1:0];
    assign w_tx = {r_rem_x, r_qx[32]};
    assign w_ty = {r_rem_y, r_qy[32]};
    assign w_mf = (r_phase == PH_SEG) ? r_step_idx : '0;
    assign w_mx = w_mf * r_step_x;
    assign w_my = w_mf * r_step_y;

    // output register
    t_out_item r_out;
    logic      r_out_valid;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_RD_SEG1: r_base <= r_rdata;
            OP_DIFF: begin
                r_neg_x <= w_dx[32];
                r_neg_y <= w_dy[32];
                r_mag_x <= w_dx[32] ? (33'd0 - w_dx) : w_dx;
                r_mag_y <= w_dy[32] ? (33'd0 - w_dy) : w_dy;
                r_mc_x  <= 66'(w_dx[32] ? (33'd0 - w_dx) : w_dx);
                r_mc_y  <= 66'(w_dy[32] ? (33'd0 - w_dy) : w_dy);
                r_acc_x <= '0;
                r_acc_y <= '0;
            end
            OP_SQ: begin
                if (r_mag_x[0]) r_acc_x <= r_acc_x + r_mc_x;
                if (r_mag_y[0]) r_acc_y <= r_acc_y + r_mc_y;
                r_mc_x  <= r_mc_x << 1;
                r_mc_y  <= r_mc_y << 1;
                r_mag_x <= r_mag_x >> 1;
                r_mag_y <= r_mag_y >> 1;
            end
            OP_SQRT_INIT: begin
                r_op  <= 67'(r_acc_x) + 67'(r_acc_y);
                r_res <= '0;
                r_one <= 67'd1 << 64;
            end
            OP_SQRT: begin
                if (r_op >= w_trial) begin
                    r_op  <= r_op - w_trial;
                    r_res <= (r_res >> 1) + r_one;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_one <= r_one >> 2;
            end
            OP_MUL: r_nprod <= r_res[33:0] * r_ppd;
            OP_DIV_INIT: begin
                r_rem_x <= '0;
                r_rem_y <= '0;
            end
            OP_DIV: begin
                if (w_tx >= {1'b0, r_pts}) begin
                    r_rem_x <= PW'(w_tx - {1'b0, r_pts});
                    r_qx    <= {r_qx[31:0], 1'b1};
                end else begin
                    r_rem_x <= w_tx[PW-1:0];
                    r_qx    <= {r_qx[31:0], 1'b0};
                end
                if (w_ty >= {1'b0, r_pts}) begin
                    r_rem_y <= PW'(w_ty - {1'b0, r_pts});
                    r_qy    <= {r_qy[31:0], 1'b1};
                end else begin
                    r_rem_y <= w_ty[PW-1:0];
                    r_qy    <= {r_qy[31:0], 1'b0};
                end
            end
            OP_PT_MUL: begin
                r_prod_x <= w_mx[31:0];
                r_prod_y <= w_my[31:0];
            end
            default: r_base <= r_base;
        endcase
        if (i_cmd.op == OP_DIFF) begin
            r_qx <= w_dx[32] ? (33'd0 - w_dx) : w_dx;
            r_qy <= w_dy[32] ? (33'd0 - w_dy) : w_dy;
        end
        if (i_cmd.op == OP_TICK) r_elapsed <= i_in_data.elapsed_time;
        if (i_cmd.op == OP_DIFF || i_cmd.op == OP_SQRT_INIT || i_cmd.op == OP_DIV_INIT) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + IterW'(1);
        end
        if (i_cmd.op == OP_EMIT_POS) begin
            r_out.pos_x <= r_rdata[63:32] + r_prod_x;
            r_out.pos_y <= r_rdata[31:0] + r_prod_y;
        end else if (i_cmd.op == OP_EMIT_ZERO) begin
            r_out.pos_x <= '0;
            r_out.pos_y <= '0;
        end
        if (i_cmd.op == OP_EMIT_POS) begin
            r_out.pos_valid <= 1'b1;
            r_out.advanced  <= i_cmd.adv;
        end else if (i_cmd.op == OP_EMIT_ZERO) begin
            r_out.pos_valid <= 1'b0;
            r_out.advanced  <= 1'b0;
        end
    end

    // walk control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DELAY;
            r_delay_pos <= '0;
            r_seg       <= '0;
            r_step_idx  <= '0;
            r_pts       <= '0;
            r_step_x    <= '0;
            r_step_y    <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_ENTER_SEG: begin
                    r_phase    <= PH_SEG;
                    r_seg      <= '0;
                    r_step_idx <= '0;
                    r_pts      <= '0;
                end
                OP_SET_LAST: r_phase <= PH_LAST;
                OP_SKIP:     r_seg   <= r_seg + AW'(1);
                OP_DIV_INIT: begin
                    r_pts      <= w_nsat;
                    r_step_idx <= '0;
                end
                OP_DIV_FIN: begin
                    r_step_x <= r_neg_x ? (32'd0 - r_qx[31:0]) : r_qx[31:0];
                    r_step_y <= r_neg_y ? (32'd0 - r_qy[31:0]) : r_qy[31:0];
                end
                OP_FIRST: r_first <= 1'b0;
                OP_ADVANCE: begin
                    case (r_phase)
                        PH_DELAY: r_delay_pos <= r_delay_pos + 8'd1;
                        PH_SEG: begin
                            if ((PW+1)'(r_step_idx) + (PW+1)'(1) >= (PW+1)'(r_pts)) begin
                                r_seg      <= r_seg + AW'(1);
                                r_step_idx <= '0;
                                r_pts      <= '0;
                            end else begin
                                r_step_idx <= r_step_idx + PW'(1);
                            end
                        end
                        default: begin
                            r_phase     <= PH_DELAY;
                            r_delay_pos <= '0;
                            r_seg       <= '0;
                            r_step_idx  <= '0;
                            r_pts       <= '0;
                        end
                    endcase
                end
                default: r_phase <= r_phase;
            endcase
            if (i_cmd.op == OP_EMIT_POS || i_cmd.op == OP_EMIT_ZERO) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_status.phase         = r_phase;
    assign o_status.delay_done    = (r_delay_pos >= r_delay);
    assign o_status.seg_active    = (r_pts != '0) && (r_step_idx < r_pts);
    assign o_status.seg_end       = (EW'(r_seg) + EW'(1) >= w_eff);
    assign o_status.npts_zero     = (w_nhi == '0);
    assign o_status.iter_last     = (r_cnt == ITER_LAST);
    assign o_status.below_dwell   = (r_elapsed < r_dwell);
    assign o_status.first_pending = r_first;
    assign o_status.out_free      = !r_out_valid || !i_out_stall;

endmodule
